/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i; ASSERT is disabled in reset, ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while out of reset.
`define ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/b128_pkg.sv */
// ----------------------------------------------------------------------------
// Base-128 varint decoder package
// Transaction types, codes and limits shared by the decoder modules.
// ----------------------------------------------------------------------------
package b128_pkg;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_EOS  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_I16  = 2'd0,
    MODE_I32  = 2'd1,
    MODE_I64  = 2'd2,
    MODE_BOOL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_PREMATURE = 2'd2,
    ST_EOS       = 2'd3
  } status_e;

  // Index of the last byte each width may use, and the bits that byte must keep clear.
  localparam logic [3:0] LastIdxI16  = 4'd3;
  localparam logic [3:0] LastIdxI32  = 4'd4;
  localparam logic [3:0] LastIdxI64  = 4'd9;
  localparam logic [7:0] LimMaskI16  = 8'hFC;
  localparam logic [7:0] LimMaskI32  = 8'hF0;
  localparam logic [7:0] LimMaskI64  = 8'hFE;
  localparam logic [7:0] BoolMask    = 8'hFE;
  localparam logic [6:0] GroupBits   = 7'd7;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  data_byte;
    mode_e       width_mode;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  idx;
    logic        busy;
    mode_e       mode;
  } state_t;

endpackage

/* hw/rtl/base128_varint_decoder.sv */
// ----------------------------------------------------------------------------
// Base-128 varint decoder
// Decodes unsigned little-endian base-128 varints from a byte stream.
// ----------------------------------------------------------------------------
// Input channel: one transaction per stream byte (opcode data) or per
// end-of-stream event; width_mode is sampled at the first byte of a value.
// Output channel: one transaction per finished value, format error or end
// event, carrying the sign-extended value and a status code.
// Both channels use valid and stall; a transaction moves on a rising edge
// with valid high and stall low.
// A byte that completes a result is first held in the input register; the
// decode step then loads the result register once that register is free, and
// the result leaves from there.
// Throughput: one input transaction per cycle unless a result is held up by
// a receiver stall; a single decode step lies between input and result registers.
// When the receiver stalls, the result register holds, and the input stalls
// only once a byte that produces a result has nowhere to go; bytes in the
// middle of a value keep flowing.
// Reset clears both valid flags and returns the decoder to idle with no value open.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base128_varint_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  b128_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output b128_pkg::out_t   out_data_o
);

  logic             in_valid_q, in_valid_d;
  b128_pkg::in_t    in_q;
  logic             out_valid_q, out_valid_d;
  b128_pkg::out_t   out_q;
  b128_pkg::state_t st_q, st_d;
  b128_pkg::state_t st_step;
  b128_pkg::out_t   res;
  logic             res_valid;
  logic             out_free;
  logic             in_consume;
  logic             in_take;

  b128_step u_step (
    .st_i       (st_q),
    .item_i     (in_q),
    .st_o       (st_step),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_consume = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !in_consume;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (in_consume ? 1'b0 : in_valid_q);
  assign out_valid_d = (in_consume && res_valid) ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
  assign st_d        = in_consume ? st_step : st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{acc: '0, idx: '0, busy: 1'b0, mode: b128_pkg::MODE_I16};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (in_consume && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT(a_err_value_zero,
          out_valid_q && (out_q.status != b128_pkg::ST_OK) |-> out_q.value == 64'sd0,
          "Error result carries a nonzero value.")
  `ASSERT(a_idx_range,
          st_q.busy |-> (st_q.idx != 4'd0) && (st_q.idx <= b128_pkg::LastIdxI64),
          "Byte index out of range while a value is open.")
  `ASSERT(a_idle_idx,
          !st_q.busy |-> st_q.idx == 4'd0,
          "Byte index not cleared while idle.")
  `ASSERT(a_no_bool_open,
          st_q.busy |-> st_q.mode != b128_pkg::MODE_BOOL,
          "Boolean value left open across bytes.")

endmodule

/* hw/rtl/b128_step.sv */
// ----------------------------------------------------------------------------
// Varint decode step
// Next decoder state and optional result for one stream byte or end event.
// ----------------------------------------------------------------------------
module b128_step (
  input  b128_pkg::state_t st_i,
  input  b128_pkg::in_t    item_i,
  output b128_pkg::state_t st_o,
  output logic             res_valid_o,
  output b128_pkg::out_t   res_o
);

  logic [7:0]  b;
  logic [6:0]  shamt;
  logic [63:0] lane;
  logic [63:0] acc_new;
  logic        bad;

  function automatic logic [63:0] finish(input logic [63:0] acc, input b128_pkg::mode_e mode);
    logic [63:0] v;
    begin
      unique case (mode)
        b128_pkg::MODE_I16: v = {{48{acc[15]}}, acc[15:0]};
        b128_pkg::MODE_I32: v = {{32{acc[31]}}, acc[31:0]};
        b128_pkg::MODE_I64,
        b128_pkg::MODE_BOOL: v = acc;
      endcase
      return v;
    end
  endfunction

  assign b       = item_i.data_byte;
  assign shamt   = 7'(st_i.idx) * b128_pkg::GroupBits;
  assign lane    = 64'(b[6:0]) << shamt;
  assign acc_new = st_i.acc | lane;

  always_comb begin
    unique case (st_i.mode)
      b128_pkg::MODE_I16:
        bad = (st_i.idx == b128_pkg::LastIdxI16) && ((b & b128_pkg::LimMaskI16) != 8'd0);
      b128_pkg::MODE_I32:
        bad = (st_i.idx == b128_pkg::LastIdxI32) && ((b & b128_pkg::LimMaskI32) != 8'd0);
      b128_pkg::MODE_I64:
        bad = (st_i.idx == b128_pkg::LastIdxI64) && ((b & b128_pkg::LimMaskI64) != 8'd0);
      b128_pkg::MODE_BOOL:
        bad = 1'b0;
    endcase
  end

  always_comb begin
    st_o         = st_i;
    res_valid_o  = 1'b0;
    res_o.value  = '0;
    res_o.status = b128_pkg::ST_OK;

    if (item_i.opcode == b128_pkg::OP_EOS) begin
      res_valid_o = 1'b1;
      if (st_i.busy) begin
        res_o.status = b128_pkg::ST_PREMATURE;
        st_o.busy    = 1'b0;
        st_o.idx     = '0;
      end else begin
        res_o.status = b128_pkg::ST_EOS;
      end
    end else if (!st_i.busy) begin
      st_o.mode = item_i.width_mode;
      if (item_i.width_mode == b128_pkg::MODE_BOOL) begin
        res_valid_o = 1'b1;
        st_o.idx    = '0;
        if ((b & b128_pkg::BoolMask) != 8'd0) begin
          res_o.status = b128_pkg::ST_INVALID;
        end else begin
          res_o.value = 64'(b[0]);
        end
      end else begin
        st_o.acc = 64'(b[6:0]);
        if (b[7]) begin
          st_o.busy = 1'b1;
          st_o.idx  = 4'd1;
        end else begin
          res_valid_o = 1'b1;
          st_o.idx    = '0;
          res_o.value = finish(64'(b[6:0]), item_i.width_mode);
        end
      end
    end else if (bad) begin
      // A byte past the width limit ends the value and drops what was gathered.
      res_valid_o  = 1'b1;
      res_o.status = b128_pkg::ST_INVALID;
      st_o.busy    = 1'b0;
      st_o.idx     = '0;
    end else begin
      st_o.acc = acc_new;
      if (b[7]) begin
        st_o.idx = st_i.idx + 4'd1;
      end else begin
        res_valid_o = 1'b1;
        res_o.value = finish(acc_new, st_i.mode);
        st_o.busy   = 1'b0;
        st_o.idx    = '0;
      end
    end
  end

endmodule

/* bench/base128_varint_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Base-128 varint decoder testbench
// Drives byte and end-of-stream transactions into the decoder with random
// idle cycles and output stalls. A scoreboard class predicts every result
// from its own copy of the decoder state and compares the results in order.
// ----------------------------------------------------------------------------
module base128_varint_decoder_tb;

  class varint_scoreboard;
    logic [63:0]       acc;
    logic [3:0]        idx;
    bit                busy;
    b128_pkg::mode_e   mode;
    b128_pkg::out_t    pending_values[$];
    int                errors;

    function new();
      acc    = '0;
      idx    = '0;
      busy   = 1'b0;
      mode   = b128_pkg::MODE_I16;
      errors = 0;
    endfunction

    function logic [63:0] extend(logic [63:0] a, b128_pkg::mode_e m);
      case (m)
        b128_pkg::MODE_I16: return {{48{a[15]}}, a[15:0]};
        b128_pkg::MODE_I32: return {{32{a[31]}}, a[31:0]};
        default:            return a;
      endcase
    endfunction

    // Advances the predicted state by one item; returns 1 when a result is due.
    function bit decode_step(b128_pkg::in_t it, output b128_pkg::out_t res);
      logic [7:0] b;
      bit         bad;
      b   = it.data_byte;
      res = '0;
      if (it.opcode == b128_pkg::OP_EOS) begin
        res.status = busy ? b128_pkg::ST_PREMATURE : b128_pkg::ST_EOS;
        busy = 1'b0;
        idx  = '0;
        return 1'b1;
      end
      if (!busy) begin
        mode = it.width_mode;
        if (mode == b128_pkg::MODE_BOOL) begin
          if ((b & b128_pkg::BoolMask) != 8'd0) res.status = b128_pkg::ST_INVALID;
          else res.value = {56'd0, b};
          return 1'b1;
        end
        acc = {57'd0, b[6:0]};
        if (b[7]) begin
          busy = 1'b1;
          idx  = 4'd1;
          return 1'b0;
        end
        res.value = extend(acc, mode);
        return 1'b1;
      end
      bad = (mode == b128_pkg::MODE_I16 && idx == b128_pkg::LastIdxI16 &&
             (b & b128_pkg::LimMaskI16) != 8'd0) ||
            (mode == b128_pkg::MODE_I32 && idx == b128_pkg::LastIdxI32 &&
             (b & b128_pkg::LimMaskI32) != 8'd0) ||
            (mode == b128_pkg::MODE_I64 && idx == b128_pkg::LastIdxI64 &&
             (b & b128_pkg::LimMaskI64) != 8'd0);
      if (bad) begin
        busy = 1'b0;
        idx  = '0;
        res.status = b128_pkg::ST_INVALID;
        return 1'b1;
      end
      // At the tenth byte only bit 0 of the group lands inside 64 bits.
      acc = acc | ({57'd0, b[6:0]} << (7 * idx));
      if (b[7]) begin
        idx = idx + 4'd1;
        return 1'b0;
      end
      busy = 1'b0;
      idx  = '0;
      res.value = extend(acc, mode);
      return 1'b1;
    endfunction

    function void note_input(b128_pkg::in_t it);
      b128_pkg::out_t res;
      if (decode_step(it, res)) pending_values.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(b128_pkg::out_t got);
      b128_pkg::out_t want;
      if (pending_values.size() == 0) begin
        report($sformatf("unexpected result value=%h status=%0d", got.value, got.status));
        return;
      end
      want = pending_values.pop_front();
      if (got.value !== want.value)
        report($sformatf("value %h, predicted %h", got.value, want.value));
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  b128_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  b128_pkg::out_t out_data_o;

  varint_scoreboard sb;
  int items_sent   = 0;
  int sender_max   = 9;
  int receiver_max = 9;

  base128_varint_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("[base128_varint_decoder] ERROR");
    $finish;
  end

  // Both channels are observed with the values they held just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // Receiver: stalls for a random number of cycles, then takes one result.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      hold = $urandom_range(0, receiver_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(b128_pkg::in_t it);
    int gap;
    gap = $urandom_range(0, sender_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, b128_pkg::mode_e m);
    b128_pkg::in_t it;
    it.opcode     = b128_pkg::OP_DATA;
    it.data_byte  = b;
    it.width_mode = m;
    send_item(it);
  endtask

  task automatic send_eos();
    b128_pkg::in_t it;
    it.opcode     = b128_pkg::OP_EOS;
    it.data_byte  = 8'($urandom);
    it.width_mode = b128_pkg::mode_e'(2'($urandom_range(0, 3)));
    send_item(it);
  endtask

  function automatic int max_len(b128_pkg::mode_e m);
    case (m)
      b128_pkg::MODE_I16: return 4;
      b128_pkg::MODE_I32: return 5;
      b128_pkg::MODE_I64: return 10;
      default:            return 1;
    endcase
  endfunction

  function automatic logic [7:0] limit_mask(b128_pkg::mode_e m);
    case (m)
      b128_pkg::MODE_I16: return b128_pkg::LimMaskI16;
      b128_pkg::MODE_I32: return b128_pkg::LimMaskI32;
      b128_pkg::MODE_I64: return b128_pkg::LimMaskI64;
      default:            return b128_pkg::BoolMask;
    endcase
  endfunction

  // Sends one value of n bytes. With break_limit set, the last byte of a
  // full-length value (or the single bool byte) sets a forbidden bit.
  task automatic send_value(b128_pkg::mode_e m, int n, bit break_limit);
    logic [7:0]      b;
    b128_pkg::mode_e first_mode;
    first_mode = m;
    for (int i = 0; i < n - 1; i++) begin
      send_byte({1'b1, 7'($urandom)}, first_mode);
      first_mode = b128_pkg::mode_e'(2'($urandom_range(0, 3)));
    end
    if (break_limit) begin
      do b = 8'($urandom); while ((b & limit_mask(m)) == 8'd0);
    end else if (m == b128_pkg::MODE_BOOL) begin
      b = 8'($urandom_range(0, 1));
    end else begin
      b = {1'b0, 7'($urandom)};
      if (n == max_len(m)) b = b & ~limit_mask(m);
    end
    send_byte(b, first_mode);
  endtask

  initial begin
    int              kind;
    int              n;
    bit              paused;
    b128_pkg::mode_e m;
    b128_pkg::in_t   noise;

    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    paused     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: limits of every width, bool cases, end events.
    send_eos();
    repeat (3) send_byte(8'hFF, b128_pkg::MODE_I16);
    send_byte(8'h03, b128_pkg::MODE_I16);
    repeat (3) send_byte(8'h80, b128_pkg::MODE_I16);
    send_byte(8'h04, b128_pkg::MODE_I16);
    repeat (4) send_byte(8'hFF, b128_pkg::MODE_I32);
    send_byte(8'h0F, b128_pkg::MODE_I32);
    repeat (9) send_byte(8'hFF, b128_pkg::MODE_I64);
    send_byte(8'h01, b128_pkg::MODE_I64);
    send_byte(8'h00, b128_pkg::MODE_BOOL);
    send_byte(8'h01, b128_pkg::MODE_BOOL);
    send_byte(8'h02, b128_pkg::MODE_BOOL);
    send_byte(8'h80, b128_pkg::MODE_I32);
    send_eos();
    send_byte(8'h00, b128_pkg::MODE_I64);

    while (items_sent < 450) begin
      case ((items_sent / 75) % 4)
        0: begin sender_max = 9; receiver_max = 9; end
        1: begin sender_max = 0; receiver_max = 0; end
        2: begin sender_max = 0; receiver_max = 9; end
        default: begin sender_max = 9; receiver_max = 0; end
      endcase
      if (!paused && items_sent >= 225) begin
        // Let every predicted result come out of the decoder before going on.
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending_values.size() != 0);
      end
      kind = $urandom_range(0, 9);
      m    = b128_pkg::mode_e'(2'($urandom_range(0, 3)));
      if (kind <= 5) begin
        n = ($urandom_range(0, 3) == 0) ? max_len(m) : $urandom_range(1, max_len(m));
        send_value(m, n, 1'b0);
      end else if (kind == 6) begin
        send_value(m, max_len(m), 1'b1);
      end else if (kind == 7) begin
        if (m == b128_pkg::MODE_BOOL) m = b128_pkg::MODE_I64;
        repeat ($urandom_range(1, max_len(m) - 1)) send_byte({1'b1, 7'($urandom)}, m);
        send_eos();
      end else if (kind == 8) begin
        send_eos();
      end else begin
        noise.opcode     = ($urandom_range(0, 3) == 0) ? b128_pkg::OP_EOS : b128_pkg::OP_DATA;
        noise.data_byte  = 8'($urandom);
        noise.width_mode = m;
        send_item(noise);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_values.size() != 0);
    repeat (10) @(posedge clk_i);
    if (sb.pending_values.size() != 0) begin
      sb.report($sformatf("%0d predicted results never arrived", sb.pending_values.size()));
    end
    if (sb.errors == 0) begin
      $display("[base128_varint_decoder] OK");
    end else begin
      $display("[base128_varint_decoder] ERROR");
    end
    $finish;
  end

endmodule

/* base128_varint_decoder.f */
+incdir+hw/rtl
hw/rtl/b128_pkg.sv
hw/rtl/b128_step.sv
hw/rtl/base128_varint_decoder.sv
bench/base128_varint_decoder_tb.sv
